### hdl/e2q_pkg.sv
// euler to quaternion: shared types, constants and the cordic arctangent table
// no dependencies; every other file imports this package
package e2q_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int TRIG_ITER_DEF   = 14;
  localparam int ATAN_ENTRIES    = 30;
  localparam int CORDIC_START    = 652032874;
  localparam int QUAT_ONE        = 16384;

  localparam int FIELD_W = 16;
  localparam int TURN_W  = 32;
  localparam int XY_W    = 34;
  localparam int Z_W     = 33;
  localparam int SC_W    = 18;
  localparam int PAIR_W  = 2 * SC_W;
  localparam int TRIP_W  = 3 * SC_W;
  localparam int SUM_W   = TRIP_W + 1;
  localparam int RND_W   = SUM_W + 1 - 31;
  localparam int QDEPTH  = 4;

  typedef struct packed {
    logic signed [FIELD_W-1:0] yaw_angle;
    logic signed [FIELD_W-1:0] pitch_angle;
    logic signed [FIELD_W-1:0] roll_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] quat_x;
    logic signed [FIELD_W-1:0] quat_y;
    logic signed [FIELD_W-1:0] quat_z;
    logic signed [FIELD_W-1:0] quat_w;
  } e2q_out_t;

  // half angles, 2^32 units per turn
  typedef struct packed {
    logic signed [TURN_W-1:0] yaw_half;
    logic signed [TURN_W-1:0] pitch_half;
    logic signed [TURN_W-1:0] roll_half;
  } e2q_half_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [TURN_W-1:0] atan_turn(input int i);
    logic [TURN_W-1:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      24:      v = 32'h00000029;
      25:      v = 32'h00000014;
      26:      v = 32'h0000000A;
      27:      v = 32'h00000005;
      28:      v = 32'h00000003;
      29:      v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/euler_to_quaternion_unit.sv
// euler angles to quaternion, top level: front stage, queue, back pipeline
// throughput: one angle triple per cycle unless out_ready stalls the output, set by the fully pipelined cordic lanes
// reset: synchronous active-low rst_n clears all valid flags and queue pointers
module euler_to_quaternion_unit #(
  parameter int ANGLE_BITS      = e2q_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_ITERATIONS = e2q_pkg::TRIG_ITER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  e2q_pkg::e2q_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output e2q_pkg::e2q_out_t out_data
);
  import e2q_pkg::*;

  logic      push_valid;
  logic      push_ready;
  e2q_half_t push_data;
  logic      pop_valid;
  logic      pop_ready;
  e2q_half_t pop_data;

  e2q_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  e2q_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  e2q_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

### hdl/e2q_front.sv
// input stage: accepts angle triples and registers the half angles
// depends on e2q_pkg
module e2q_front #(
  parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  e2q_pkg::e2q_in_t   in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output e2q_pkg::e2q_half_t push_data
);
  import e2q_pkg::*;

  localparam int SHIFT = TURN_W - ANGLE_BITS;

  logic      valid_r;
  e2q_half_t half_r;

  // low ANGLE_BITS of the field go to the top of a 32-bit turn, then halve
  function automatic logic signed [TURN_W-1:0] half_of(input logic [FIELD_W-1:0] a);
    logic [TURN_W-1:0] ext;
    logic [TURN_W-1:0] p;
    ext = {{(TURN_W-FIELD_W){1'b0}}, a};
    p   = ext << SHIFT;
    return $signed(p) >>> 1;
  endfunction

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_data  = half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      half_r.yaw_half   <= half_of(in_data.yaw_angle);
      half_r.pitch_half <= half_of(in_data.pitch_angle);
      half_r.roll_half  <= half_of(in_data.roll_angle);
    end
  end

endmodule

### hdl/e2q_queue.sv
// short fifo between the front stage and the trig/product pipeline
// depends on e2q_pkg
module e2q_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  e2q_pkg::e2q_half_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output e2q_pkg::e2q_half_t pop_data
);
  import e2q_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  e2q_half_t        entry_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hdl/e2q_cordic.sv
// pipelined rotation-mode cordic, one stage per iteration, q15 cos/sin out
// depends on e2q_pkg
module e2q_cordic #(
  parameter int STAGES = e2q_pkg::TRIG_ITER_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [e2q_pkg::TURN_W-1:0] z_in,
  output logic signed [e2q_pkg::SC_W-1:0]   cos_out,
  output logic signed [e2q_pkg::SC_W-1:0]   sin_out
);
  import e2q_pkg::*;

  logic signed [XY_W-1:0] x_r [STAGES];
  logic signed [XY_W-1:0] y_r [STAGES];
  logic signed [Z_W-1:0]  z_r [STAGES];
  logic signed [XY_W-1:0] x_rnd;
  logic signed [XY_W-1:0] y_rnd;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic signed [XY_W-1:0] xp;
    logic signed [XY_W-1:0] yp;
    logic signed [Z_W-1:0]  zp;
    logic signed [Z_W-1:0]  atan_s;

    if (s == 0) begin : g_first
      assign xp = XY_W'(CORDIC_START);
      assign yp = '0;
      assign zp = Z_W'(z_in);
    end else begin : g_next
      assign xp = x_r[s-1];
      assign yp = y_r[s-1];
      assign zp = z_r[s-1];
    end

    assign atan_s = $signed({1'b0, atan_turn(s)});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zp[Z_W-1]) begin
          x_r[s] <= xp - (yp >>> s);
          y_r[s] <= yp + (xp >>> s);
          z_r[s] <= zp - atan_s;
        end else begin
          x_r[s] <= xp + (yp >>> s);
          y_r[s] <= yp - (xp >>> s);
          z_r[s] <= zp + atan_s;
        end
      end
    end
  end

  // q30 to q15 with rounding
  assign x_rnd = (x_r[STAGES-1] + XY_W'(16384)) >>> 15;
  assign y_rnd = (y_r[STAGES-1] + XY_W'(16384)) >>> 15;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= x_rnd[SC_W-1:0];
      sin_out <= y_rnd[SC_W-1:0];
    end
  end

endmodule

### hdl/e2q_back.sv
// back pipeline: three cordic lanes, triple products, rounding and clamping
// depends on e2q_pkg and e2q_cordic
module e2q_back #(
  parameter int TRIG_ITERATIONS = e2q_pkg::TRIG_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  e2q_pkg::e2q_half_t pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output e2q_pkg::e2q_out_t  out_data
);
  import e2q_pkg::*;

  localparam int STAGES = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
  // cordic stages, q15 convert, pair products, triple products, sums
  localparam int VLD_N = STAGES + 4;

  logic                     adv;
  logic [VLD_N-1:0]         vld_r;
  logic                     out_valid_r;
  e2q_out_t                 out_data_r;

  logic signed [SC_W-1:0]   cy, sy, cp, sp, cr, sr;
  logic signed [PAIR_W-1:0] crsp_r, srcp_r, crcp_r, srsp_r;
  logic signed [SC_W-1:0]   cy_b_r, sy_b_r;
  logic signed [TRIP_W-1:0] trip_r [8];
  logic signed [SUM_W-1:0]  sum_r [4];

  function automatic logic signed [FIELD_W-1:0] finish(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W:0]    t;
    logic signed [SUM_W:0]    sh;
    logic signed [RND_W-1:0]  r;
    t  = (SUM_W+1)'(v) + (SUM_W+1)'(64'sd1073741824);
    sh = t >>> 31;
    r  = sh[RND_W-1:0];
    if (r > QUAT_ONE) begin
      r = RND_W'(QUAT_ONE);
    end else if (r < -QUAT_ONE) begin
      r = -RND_W'(QUAT_ONE);
    end
    return r[FIELD_W-1:0];
  endfunction

  // whole pipeline moves together unless the output word is stuck
  assign adv       = !out_valid_r || out_ready;
  assign pop_ready = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  e2q_cordic #(.STAGES(STAGES)) u_yaw (
    .clk    (clk),
    .en     (adv),
    .z_in   (pop_data.yaw_half),
    .cos_out(cy),
    .sin_out(sy)
  );

  e2q_cordic #(.STAGES(STAGES)) u_pitch (
    .clk    (clk),
    .en     (adv),
    .z_in   (pop_data.pitch_half),
    .cos_out(cp),
    .sin_out(sp)
  );

  e2q_cordic #(.STAGES(STAGES)) u_roll (
    .clk    (clk),
    .en     (adv),
    .z_in   (pop_data.roll_half),
    .cos_out(cr),
    .sin_out(sr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[VLD_N-2:0], pop_valid};
      out_valid_r <= vld_r[VLD_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // roll/pitch pair products, yaw terms delayed to match
      crsp_r <= cr * sp;
      srcp_r <= sr * cp;
      crcp_r <= cr * cp;
      srsp_r <= sr * sp;
      cy_b_r <= cy;
      sy_b_r <= sy;

      trip_r[0] <= crsp_r * cy_b_r;
      trip_r[1] <= srcp_r * sy_b_r;
      trip_r[2] <= crcp_r * sy_b_r;
      trip_r[3] <= srsp_r * cy_b_r;
      trip_r[4] <= srcp_r * cy_b_r;
      trip_r[5] <= crsp_r * sy_b_r;
      trip_r[6] <= crcp_r * cy_b_r;
      trip_r[7] <= srsp_r * sy_b_r;

      sum_r[0] <= SUM_W'(trip_r[0]) + SUM_W'(trip_r[1]);
      sum_r[1] <= SUM_W'(trip_r[2]) - SUM_W'(trip_r[3]);
      sum_r[2] <= SUM_W'(trip_r[4]) - SUM_W'(trip_r[5]);
      sum_r[3] <= SUM_W'(trip_r[6]) + SUM_W'(trip_r[7]);

      out_data_r.quat_x <= finish(sum_r[0]);
      out_data_r.quat_y <= finish(sum_r[1]);
      out_data_r.quat_z <= finish(sum_r[2]);
      out_data_r.quat_w <= finish(sum_r[3]);
    end
  end

endmodule

### tb/sv/euler_to_quaternion_unit_tb.sv
// testbench for euler_to_quaternion_unit: directed and random angle triples with
// random gaps and stalls on both channels, checked against a cordic-based predictor
// depends on e2q_pkg (word types) and the euler_to_quaternion_unit rtl
module euler_to_quaternion_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import e2q_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_WORDS = 750;
  localparam int DRAIN_CYCLES = 40;

  // expected quaternions for accepted angle words, oldest first
  class quat_scoreboard;
    localparam int ANG_BITS  = ANGLE_BITS_DEF;
    localparam int CORDIC_N  = TRIG_ITER_DEF;
    localparam int LUT_SIZE  = 30;
    localparam longint GAIN_INV = 64'sd652032874;
    localparam longint UNIT_Q14 = 64'sd16384;
    localparam longint ATAN_LUT [0:29] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    e2q_out_t quat_q[$];
    int       mismatches;
    int       words_in;
    int       words_out;

    function new();
      mismatches = 0;
      words_in   = 0;
      words_out  = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // cosine and sine of half the binary angle, both q15
    function automatic void half_trig(logic [FIELD_W-1:0] raw, output longint c15,
                                      output longint s15);
      logic [31:0] turn;
      longint      x, y, z, dx, dy;
      turn = 32'(raw) << (32 - ANG_BITS);
      z = longint'($signed(turn)) >>> 1;
      x = GAIN_INV;
      y = 0;
      for (int i = 0; i < CORDIC_N && i < LUT_SIZE; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_LUT[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_LUT[i];
        end
      end
      c15 = (x + (longint'(1) << 14)) >>> 15;
      s15 = (y + (longint'(1) << 14)) >>> 15;
    endfunction

    // q45 sum to q14, saturated to plus or minus one
    function automatic logic [FIELD_W-1:0] to_q14(longint q45);
      longint v;
      v = (q45 + (longint'(1) << 30)) >>> 31;
      if (v > UNIT_Q14) v = UNIT_Q14;
      if (v < -UNIT_Q14) v = -UNIT_Q14;
      return v[FIELD_W-1:0];
    endfunction

    function automatic e2q_out_t angles_to_quat(e2q_in_t a);
      longint   cy, sy, cp, sp, cr, sr;
      e2q_out_t q;
      half_trig(a.yaw_angle, cy, sy);
      half_trig(a.pitch_angle, cp, sp);
      half_trig(a.roll_angle, cr, sr);
      q.quat_x = to_q14(cr * sp * cy + sr * cp * sy);
      q.quat_y = to_q14(cr * cp * sy - sr * sp * cy);
      q.quat_z = to_q14(sr * cp * cy - cr * sp * sy);
      q.quat_w = to_q14(cr * cp * cy + sr * sp * sy);
      return q;
    endfunction

    function void note_input(e2q_in_t a);
      quat_q.push_back(angles_to_quat(a));
      words_in++;
    endfunction

    task check_result(e2q_out_t got);
      e2q_out_t want;
      words_out++;
      if (quat_q.size() == 0) begin
        report($sformatf("result %0d with nothing expected: %h", words_out, got));
      end else begin
        want = quat_q.pop_front();
        if (got.quat_x !== want.quat_x)
          report($sformatf("result %0d quat_x got %0d want %0d", words_out,
                           $signed(got.quat_x), $signed(want.quat_x)));
        if (got.quat_y !== want.quat_y)
          report($sformatf("result %0d quat_y got %0d want %0d", words_out,
                           $signed(got.quat_y), $signed(want.quat_y)));
        if (got.quat_z !== want.quat_z)
          report($sformatf("result %0d quat_z got %0d want %0d", words_out,
                           $signed(got.quat_z), $signed(want.quat_z)));
        if (got.quat_w !== want.quat_w)
          report($sformatf("result %0d quat_w got %0d want %0d", words_out,
                           $signed(got.quat_w), $signed(want.quat_w)));
      end
    endtask

    function int pending();
      return quat_q.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  e2q_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  e2q_out_t out_data;

  quat_scoreboard quat_sb;
  int             cycle_count = 0;

  euler_to_quaternion_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) quat_sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) quat_sb.check_result(out_data);
  end

  bit send_steady;
  bit recv_steady;

  task automatic send_angles(e2q_in_t a);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= a;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_triple(int yaw, int pitch, int roll);
    e2q_in_t a;
    a.yaw_angle   = yaw[FIELD_W-1:0];
    a.pitch_angle = pitch[FIELD_W-1:0];
    a.roll_angle  = roll[FIELD_W-1:0];
    send_angles(a);
  endtask

  // hold off the sender until every expected quaternion is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (quat_sb.pending() != 0) @(negedge clk);
  endtask

  task automatic take_results();
    int stall;
    int taken;
    taken = 0;
    forever begin
      if (taken % 48 == 0) recv_steady = ($urandom_range(0, 3) == 0);
      stall = recv_steady ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  endtask

  // random angle near a sensitive point: zero, quarter and half turns, eighths
  function automatic logic [FIELD_W-1:0] near_corner();
    int corners [8] = '{0, 16384, -16384, -32768, 32767, 8192, -8192, 24576};
    return FIELD_W'(corners[3'($urandom_range(0, 7))] + $urandom_range(0, 8) - 4);
  endfunction

  function automatic e2q_in_t random_angles();
    e2q_in_t a;
    int      pick;
    pick = $urandom_range(0, 9);
    a = e2q_in_t'((3*FIELD_W)'({$urandom, $urandom}));
    if (pick < 2) begin
      a.yaw_angle   = near_corner();
      a.pitch_angle = near_corner();
      a.roll_angle  = near_corner();
    end else if (pick < 4) begin
      // single axis rotation
      case ($urandom_range(0, 2))
        0: begin
          a.pitch_angle = '0;
          a.roll_angle  = '0;
        end
        1: begin
          a.yaw_angle  = '0;
          a.roll_angle = '0;
        end
        default: begin
          a.yaw_angle   = '0;
          a.pitch_angle = '0;
        end
      endcase
    end
    return a;
  endfunction

  initial begin
    quat_sb     = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    send_steady = 1'b0;
    recv_steady = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    fork
      take_results();
    join_none

    // directed: identity, half, quarter and eighth turns, extremes, small angles and bit patterns
    send_triple(0, 0, 0);
    send_triple(-32768, 0, 0);
    send_triple(0, -32768, 0);
    send_triple(0, 0, -32768);
    send_triple(-32768, -32768, -32768);
    send_triple(32767, 32767, 32767);
    send_triple(16384, 0, 0);
    send_triple(0, 16384, 0);
    send_triple(0, 0, 16384);
    send_triple(-16384, -16384, -16384);
    send_triple(8192, 8192, 8192);
    send_triple(1, -1, 1);
    send_triple(-1, 1, -1);
    send_triple(32767, -32768, 0);
    send_triple(-32768, 32767, 16384);
    send_triple('h5555, 'hAAAA, 'h5555);
    send_triple('hAAAA, 'h5555, 'hAAAA);
    send_triple('hFFFF, 'h0000, 'h8001);
    send_triple(12345, -23456, 31000);
    wait_drained();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) send_steady = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 2) wait_drained();
      send_angles(random_angles());
    end
    in_valid <= 1'b0;

    while (quat_sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (quat_sb.pending() != 0)
      quat_sb.report($sformatf("%0d quaternions never arrived", quat_sb.pending()));

    $display("covered %0d angle words and %0d quaternion words in %0d cycles",
             quat_sb.words_in, quat_sb.words_out, cycle_count);
    $display("directed corners plus random triples, with gaps and stalls on both sides");
    if (quat_sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", quat_sb.mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
